// ----- rtl/tlbli_pkg.sv -----
// ----------------------------------------------------------------------------
// tlbli_pkg: shared types and constants of the translation lookaside buffer
// Command codes, controller states and the command and status groups that
// join the controller and the datapath.
// ----------------------------------------------------------------------------
package tlbli_pkg;

   // Width of the access right field.
   localparam int ACCESS_BITS = 2;

   // Request command codes.
   typedef enum logic [1:0] {
      CMD_LOOKUP = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_FLUSH  = 2'd2,
      CMD_NOP    = 2'd3
   } tlbli_cmd_type;

   // Controller states.
   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } tlbli_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;       // capture the request and restart the scan
      logic scan;       // issue the next entry read
      logic write_hit;  // rewrite the matching entry with the new frame
      logic append;     // write a new entry at the fill position
      logic flush;      // empty the table
      logic respond;    // present a response next cycle
      logic rsp_hit;    // the response reports a hit
      logic rsp_drop;   // the response reports a dropped insert
   } tlbli_ctrl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      tlbli_cmd_type cmd;  // captured command
      logic match;         // entry under compare matches the request
      logic scan_end;      // all filled entries compared, none in flight
      logic full;          // every entry is filled
   } tlbli_stat_type;

endpackage

// ----- rtl/tlb_lookup_insert.sv -----
// Lookups and inserts scan the filled entries through the single read port, one entry
// per cycle, and respond on a match or once the filled entries are exhausted.
// One transaction at a time: a new one is accepted only while the controller is idle,
// after the last one has finished its scan.
// Reset empties the table (fill count 0) and returns the controller to idle.
// The response strobe lasts one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
// tlb_lookup_insert: fully associative translation lookaside buffer
// Entries fill in order; lookups and inserts scan the filled entries, flush
// empties the table.
// ----------------------------------------------------------------------------
module tlb_lookup_insert
   import tlbli_pkg::*;
#(
   parameter int TLB_ENTRIES = 256,
   parameter int PAGE_BITS   = 8,
   parameter int FRAME_BITS  = 7
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [1:0]             req_cmd,
   input  logic [PAGE_BITS-1:0]   req_page_number,
   input  logic [ACCESS_BITS-1:0] req_access,
   input  logic [FRAME_BITS-1:0]  req_frame_in,
   output logic                   rsp_valid,
   output logic                   rsp_hit,
   output logic [FRAME_BITS-1:0]  rsp_frame_found,
   output logic                   rsp_status
);

   tlbli_ctrl_type ctrl;
   tlbli_stat_type stat;

   // Controller.
   tlbli_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   // Datapath.
   tlbli_dpath #(
      .TLB_ENTRIES (TLB_ENTRIES),
      .PAGE_BITS   (PAGE_BITS),
      .FRAME_BITS  (FRAME_BITS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_cmd         (req_cmd),
      .req_page_number (req_page_number),
      .req_access      (req_access),
      .req_frame_in    (req_frame_in),
      .ctrl            (ctrl),
      .stat            (stat),
      .rsp_valid       (rsp_valid),
      .rsp_hit         (rsp_hit),
      .rsp_frame_found (rsp_frame_found),
      .rsp_status      (rsp_status)
   );

endmodule

// ----- rtl/tlbli_ctrl.sv -----
// ----------------------------------------------------------------------------
// tlbli_ctrl: controller of the translation lookaside buffer
// Accepts a transaction, steers the entry scan and decides the outcome once
// a match is found or the filled entries are exhausted.
// ----------------------------------------------------------------------------
module tlbli_ctrl
   import tlbli_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   output logic           busy,
   input  tlbli_stat_type stat,
   output tlbli_ctrl_type ctrl
);

   tlbli_state_type state_ff;
   tlbli_state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state: lookups and inserts finish when the scan yields an outcome, other commands without a scan.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            case (stat.cmd)
               CMD_LOOKUP, CMD_INSERT: begin
                  if (stat.match || stat.scan_end) begin
                     state_in = ST_IDLE;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs to the datapath.
   always_comb begin
      ctrl = '0;
      busy = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            ctrl.load = start;
         end
         ST_SCAN: begin
            case (stat.cmd)
               CMD_LOOKUP: begin
                  if (stat.match) begin
                     ctrl.respond = 1'b1;
                     ctrl.rsp_hit = 1'b1;
                  end else if (stat.scan_end) begin
                     ctrl.respond = 1'b1;
                  end else begin
                     ctrl.scan = 1'b1;
                  end
               end
               CMD_INSERT: begin
                  if (stat.match) begin
                     ctrl.write_hit = 1'b1;
                     ctrl.respond   = 1'b1;
                  end else if (stat.scan_end) begin
                     ctrl.respond  = 1'b1;
                     ctrl.rsp_drop = stat.full;
                     ctrl.append   = !stat.full;
                  end else begin
                     ctrl.scan = 1'b1;
                  end
               end
               CMD_FLUSH: begin
                  ctrl.flush   = 1'b1;
                  ctrl.respond = 1'b1;
               end
               default: begin
                  ctrl.respond = 1'b1;
               end
            endcase
         end
         default: begin
            ctrl = '0;
         end
      endcase
   end

endmodule

// ----- rtl/tlbli_dpath.sv -----
// ----------------------------------------------------------------------------
// tlbli_dpath: datapath of the translation lookaside buffer
// Holds the entry memory, the fill count, the scan address and compare stage,
// and the response registers.
// ----------------------------------------------------------------------------
module tlbli_dpath
   import tlbli_pkg::*;
#(
   parameter int TLB_ENTRIES = 256,
   parameter int PAGE_BITS   = 8,
   parameter int FRAME_BITS  = 7
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [1:0]            req_cmd,
   input  logic [PAGE_BITS-1:0]  req_page_number,
   input  logic [ACCESS_BITS-1:0] req_access,
   input  logic [FRAME_BITS-1:0] req_frame_in,
   input  tlbli_ctrl_type        ctrl,
   output tlbli_stat_type        stat,
   output logic                  rsp_valid,
   output logic                  rsp_hit,
   output logic [FRAME_BITS-1:0] rsp_frame_found,
   output logic                  rsp_status
);

   localparam int IDX_W   = $clog2(TLB_ENTRIES);
   localparam int CNT_W   = $clog2(TLB_ENTRIES + 1);
   localparam int ENTRY_W = ACCESS_BITS + PAGE_BITS + FRAME_BITS;

   // Entry memory: {right, page, frame}.
   logic [ENTRY_W-1:0] mem [TLB_ENTRIES];

   tlbli_cmd_type          cmd_ff;
   logic [PAGE_BITS-1:0]   page_ff;
   logic [ACCESS_BITS-1:0] access_ff;
   logic [FRAME_BITS-1:0]  frame_ff;

   logic [CNT_W-1:0]   fill_ff;
   logic [CNT_W-1:0]   rd_idx_ff;
   logic [CNT_W-1:0]   rd_idx_in;
   logic [IDX_W-1:0]   cmp_idx_ff;
   logic               rvalid_ff;
   logic               rvalid_in;
   logic [ENTRY_W-1:0] rdata_ff;

   logic                   issue;
   logic [PAGE_BITS-1:0]   ent_page;
   logic [ACCESS_BITS-1:0] ent_right;
   logic [FRAME_BITS-1:0]  ent_frame;
   logic                   right_ok;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;

   logic                  rsp_valid_ff;
   logic                  rsp_hit_ff;
   logic [FRAME_BITS-1:0] rsp_frame_ff;
   logic                  rsp_status_ff;

   // Capture of the accepted transaction.
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         cmd_ff    <= tlbli_cmd_type'(req_cmd);
         page_ff   <= req_page_number;
         access_ff <= req_access;
         frame_ff  <= req_frame_in;
      end
   end

   // Scan address: one entry read issued per cycle while the controller scans, until the fill count.
   assign issue     = ctrl.scan && (rd_idx_ff < fill_ff);
   assign rvalid_in = issue;
   always_comb begin
      rd_idx_in = rd_idx_ff;
      if (ctrl.load) begin
         rd_idx_in = '0;
      end else if (issue) begin
         rd_idx_in = rd_idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_idx_ff <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         rd_idx_ff <= rd_idx_in;
         rvalid_ff <= rvalid_in && !ctrl.load;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         cmp_idx_ff <= rd_idx_ff[IDX_W-1:0];
      end
   end

   // Memory write: an update rewrites the matching entry, an append the next one.
   assign wr_en   = ctrl.write_hit || ctrl.append;
   assign wr_addr = ctrl.write_hit ? cmp_idx_ff : fill_ff[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {access_ff, page_ff, frame_ff};
      end
   end

   // Memory read with registered data.
   always_ff @(posedge clock) begin
      rdata_ff <= mem[rd_idx_ff[IDX_W-1:0]];
   end

   // Fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (ctrl.flush) begin
         fill_ff <= '0;
      end else if (ctrl.append) begin
         fill_ff <= fill_ff + 1'b1;
      end
   end

   // Compare stage: lookups accept an equal or higher right, inserts need an equal one.
   assign ent_frame = rdata_ff[FRAME_BITS-1:0];
   assign ent_page  = rdata_ff[FRAME_BITS +: PAGE_BITS];
   assign ent_right = rdata_ff[FRAME_BITS+PAGE_BITS +: ACCESS_BITS];
   assign right_ok  = (cmd_ff == CMD_LOOKUP) ? (ent_right >= access_ff)
                                             : (ent_right == access_ff);

   always_comb begin
      stat.cmd      = cmd_ff;
      stat.match    = rvalid_ff && (ent_page == page_ff) && right_ok;
      stat.scan_end = !rvalid_ff && (rd_idx_ff == fill_ff);
      stat.full     = (fill_ff == CNT_W'(TLB_ENTRIES));
   end

   // Response registers: the strobe lasts exactly one cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         rsp_hit_ff    <= 1'b0;
         rsp_status_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= ctrl.respond;
         rsp_hit_ff    <= ctrl.respond && ctrl.rsp_hit;
         rsp_status_ff <= ctrl.respond && ctrl.rsp_drop;
      end
   end

   always_ff @(posedge clock) begin
      rsp_frame_ff <= (ctrl.respond && ctrl.rsp_hit) ? ent_frame : '0;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_frame_found = rsp_frame_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

// ----- rtl/tlbli_checker.sv -----
// ----------------------------------------------------------------------------
// tlbli_checker: port-level checks of the translation lookaside buffer
// Watches the command and response ports for ordering and field rules.
// ----------------------------------------------------------------------------
module tlbli_checker #(
   parameter int FRAME_BITS = 7
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic                  rsp_valid,
   input logic                  rsp_hit,
   input logic [FRAME_BITS-1:0] rsp_frame_found,
   input logic                  rsp_status
);

   // An accepted transaction makes the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("block not busy after an accepted transaction");

   // A response is shown only once the block is ready for the next transaction.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response shown while busy");

   // Responses never come in two consecutive cycles.
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   // Hit and drop flags appear only on a response, and never together.
   a_rsp_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_hit || rsp_status) |-> rsp_valid && !(rsp_hit && rsp_status))
      else $error("inconsistent response flags");

   // A response without a hit carries frame zero.
   a_miss_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_frame_found == '0)
      else $error("nonzero frame without a hit");

endmodule

bind tlb_lookup_insert tlbli_checker #(.FRAME_BITS(FRAME_BITS)) u_tlbli_checker (.*);

// ----- tb/tlb_txn_checker.sv -----
// ----------------------------------------------------------------------------
// tlb_txn_checker: transaction predictor and response checker for the TLB
// Watches the request and response channels of tlb_lookup_insert, keeps its
// own copy of the translation table, predicts the response of every accepted
// request and compares each response, field by field, with the oldest one.
// ----------------------------------------------------------------------------
module tlb_txn_checker
   import tlbli_pkg::*;
#(
   parameter int TLB_ENTRIES = 256,
   parameter int PAGE_BITS   = 8,
   parameter int FRAME_BITS  = 7
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   busy,
   input  logic [1:0]             req_cmd,
   input  logic [PAGE_BITS-1:0]   req_page_number,
   input  logic [ACCESS_BITS-1:0] req_access,
   input  logic [FRAME_BITS-1:0]  req_frame_in,
   input  logic                   rsp_valid,
   input  logic                   rsp_hit,
   input  logic [FRAME_BITS-1:0]  rsp_frame_found,
   input  logic                   rsp_status,
   output int                     fail_count,
   output int                     pending_count
);

   timeunit 1ns;
   timeprecision 1ps;

   // One predicted response.
   typedef struct packed {
      logic                  hit;
      logic [FRAME_BITS-1:0] frame;
      logic                  status;
   } tlb_rsp_type;

   // Shadow copy of the translation table.
   int                     shadow_fill;
   logic [PAGE_BITS-1:0]   shadow_page  [TLB_ENTRIES];
   logic [ACCESS_BITS-1:0] shadow_right [TLB_ENTRIES];
   logic [FRAME_BITS-1:0]  shadow_frame [TLB_ENTRIES];

   tlb_rsp_type expected_rsps[$];
   int          failures;

   // Applies one request to the shadow table and returns its response.
   function automatic tlb_rsp_type translate_and_update(
      input tlbli_cmd_type          cmd,
      input logic [PAGE_BITS-1:0]   page,
      input logic [ACCESS_BITS-1:0] right,
      input logic [FRAME_BITS-1:0]  frame
   );
      tlb_rsp_type rsp;
      logic        found;
      rsp   = '0;
      found = 1'b0;
      case (cmd)
         CMD_LOOKUP: begin
            // The first entry with the same page and a right high enough wins.
            for (int i = 0; i < shadow_fill && !found; i++) begin
               if (shadow_page[i] == page && shadow_right[i] >= right) begin
                  found     = 1'b1;
                  rsp.hit   = 1'b1;
                  rsp.frame = shadow_frame[i];
               end
            end
         end
         CMD_INSERT: begin
            // Update an entry with equal page and right, else append one.
            for (int i = 0; i < shadow_fill && !found; i++) begin
               if (shadow_page[i] == page && shadow_right[i] == right) begin
                  found           = 1'b1;
                  shadow_frame[i] = frame;
               end
            end
            if (!found) begin
               if (shadow_fill < TLB_ENTRIES) begin
                  shadow_page[shadow_fill]  = page;
                  shadow_right[shadow_fill] = right;
                  shadow_frame[shadow_fill] = frame;
                  shadow_fill++;
               end else begin
                  rsp.status = 1'b1;
               end
            end
         end
         CMD_FLUSH: begin
            shadow_fill = 0;
         end
         default: begin
         end
      endcase
      return rsp;
   endfunction

   // Counts one failure and reports the first ten of them.
   task automatic report_failure(input string what);
      failures++;
      if (failures <= 10) begin
         $display("[%0t] tlb mismatch: %s", $time, what);
      end
   endtask

   // Responses are checked before a new request is predicted, so a response
   // and the next acceptance on the same edge stay in order.
   always @(posedge clock) begin
      tlb_rsp_type want;
      if (reset) begin
         shadow_fill = 0;
         expected_rsps.delete();
         failures = 0;
      end else begin
         if (rsp_valid) begin
            if (expected_rsps.size() == 0) begin
               report_failure($sformatf("response with nothing expected: hit %0d frame %0d status %0d",
                                        rsp_hit, rsp_frame_found, rsp_status));
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_hit !== want.hit) begin
                  report_failure($sformatf("hit expected %0d actual %0d", want.hit, rsp_hit));
               end
               if (rsp_frame_found !== want.frame) begin
                  report_failure($sformatf("frame_found expected %0d actual %0d",
                                           want.frame, rsp_frame_found));
               end
               if (rsp_status !== want.status) begin
                  report_failure($sformatf("status expected %0d actual %0d",
                                           want.status, rsp_status));
               end
            end
         end
         if (start && !busy) begin
            expected_rsps.push_back(translate_and_update(tlbli_cmd_type'(req_cmd),
                                                         req_page_number, req_access,
                                                         req_frame_in));
         end
      end
      fail_count    <= failures;
      pending_count <= expected_rsps.size();
   end

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: testbench of tlb_lookup_insert
// Drives directed requests, a full-table fill with dropped inserts and random
// flush-delimited episodes of inserts and lookups over small page sets, with
// random sender gaps; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;

   import tlbli_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TLB_ENTRIES    = 256;
   localparam int PAGE_BITS      = 8;
   localparam int FRAME_BITS     = 7;
   localparam int PHASE_ITEMS    = 350;
   localparam int CYCLE_LIMIT    = 2_000_000;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic [1:0]             req_cmd;
   logic [PAGE_BITS-1:0]   req_page_number;
   logic [ACCESS_BITS-1:0] req_access;
   logic [FRAME_BITS-1:0]  req_frame_in;
   logic                   rsp_valid;
   logic                   rsp_hit;
   logic [FRAME_BITS-1:0]  rsp_frame_found;
   logic                   rsp_status;
   int                     fail_count;
   int                     pending_count;
   int                     idle_pct;
   int                     issued;
   int                     cycles;

   tlb_lookup_insert #(
      .TLB_ENTRIES (TLB_ENTRIES),
      .PAGE_BITS   (PAGE_BITS),
      .FRAME_BITS  (FRAME_BITS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_page_number (req_page_number),
      .req_access      (req_access),
      .req_frame_in    (req_frame_in),
      .rsp_valid       (rsp_valid),
      .rsp_hit         (rsp_hit),
      .rsp_frame_found (rsp_frame_found),
      .rsp_status      (rsp_status)
   );

   tlb_txn_checker #(
      .TLB_ENTRIES (TLB_ENTRIES),
      .PAGE_BITS   (PAGE_BITS),
      .FRAME_BITS  (FRAME_BITS)
   ) checker_i (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_page_number (req_page_number),
      .req_access      (req_access),
      .req_frame_in    (req_frame_in),
      .rsp_valid       (rsp_valid),
      .rsp_hit         (rsp_hit),
      .rsp_frame_found (rsp_frame_found),
      .rsp_status      (rsp_status),
      .fail_count      (fail_count),
      .pending_count   (pending_count)
   );

   // Clock with an 8 ns period.
   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("** tlb_lookup_insert: FAILED **");
         $finish;
      end
   end

   // Issues one transaction, after a random gap when the sender idles, and
   // returns at the edge that accepts it.
   task automatic issue(
      input tlbli_cmd_type          cmd,
      input logic [PAGE_BITS-1:0]   page,
      input logic [ACCESS_BITS-1:0] right,
      input logic [FRAME_BITS-1:0]  frame
   );
      int gap;
      gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 6) : 0;
      repeat (gap) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start           <= 1'b1;
      req_cmd         <= cmd;
      req_page_number <= page;
      req_access      <= right;
      req_frame_in    <= frame;
      @(posedge clock);
      while (busy) @(posedge clock);
      issued++;
   endtask

   // Fills the whole table, then inserts that must be dropped or update.
   task automatic fill_to_capacity();
      issue(CMD_FLUSH, PAGE_BITS'($urandom), ACCESS_BITS'($urandom), FRAME_BITS'($urandom));
      for (int i = 0; i < TLB_ENTRIES; i++) begin
         issue(CMD_INSERT, PAGE_BITS'(i), ACCESS_BITS'($urandom), FRAME_BITS'($urandom));
      end
      // Only one of the four rights matches the stored entry of page 0.
      for (int a = 0; a < 4; a++) begin
         issue(CMD_INSERT, '0, ACCESS_BITS'(a), FRAME_BITS'($urandom));
      end
      issue(CMD_INSERT, '1, ACCESS_BITS'($urandom), FRAME_BITS'($urandom));
      issue(CMD_INSERT, PAGE_BITS'($urandom_range(1, 254)), ACCESS_BITS'($urandom),
            FRAME_BITS'($urandom));
      issue(CMD_LOOKUP, '0, 2'd0, '0);
      issue(CMD_LOOKUP, '1, 2'd0, '0);
      issue(CMD_LOOKUP, '1, 2'd3, '0);
      issue(CMD_LOOKUP, PAGE_BITS'($urandom_range(1, 254)), ACCESS_BITS'($urandom),
            FRAME_BITS'($urandom));
      issue(CMD_NOP, PAGE_BITS'($urandom), ACCESS_BITS'($urandom), FRAME_BITS'($urandom));
   endtask

   // A flush followed by inserts and lookups over a small set of pages, so
   // that updates and hits are common, with some noise mixed in.
   task automatic run_episode();
      logic [PAGE_BITS-1:0] pages [0:7];
      int                   n_pages;
      int                   len;
      int                   r;
      n_pages = $urandom_range(1, 8);
      for (int i = 0; i < 8; i++) begin
         pages[i] = PAGE_BITS'($urandom);
      end
      issue(CMD_FLUSH, PAGE_BITS'($urandom), ACCESS_BITS'($urandom), FRAME_BITS'($urandom));
      len = $urandom_range(4, 48);
      repeat (len) begin
         r = $urandom_range(0, 99);
         if (r < 40) begin
            issue(CMD_INSERT, pages[$urandom_range(0, n_pages - 1)],
                  ACCESS_BITS'($urandom), FRAME_BITS'($urandom));
         end else if (r < 82) begin
            issue(CMD_LOOKUP, pages[$urandom_range(0, n_pages - 1)],
                  ACCESS_BITS'($urandom), FRAME_BITS'($urandom));
         end else if (r < 90) begin
            issue(CMD_LOOKUP, PAGE_BITS'($urandom), ACCESS_BITS'($urandom),
                  FRAME_BITS'($urandom));
         end else if (r < 95) begin
            issue(CMD_INSERT, PAGE_BITS'($urandom), ACCESS_BITS'($urandom),
                  FRAME_BITS'($urandom));
         end else if (r < 98) begin
            issue(CMD_NOP, PAGE_BITS'($urandom), ACCESS_BITS'($urandom),
                  FRAME_BITS'($urandom));
         end else begin
            issue(CMD_FLUSH, PAGE_BITS'($urandom), ACCESS_BITS'($urandom),
                  FRAME_BITS'($urandom));
         end
      end
   endtask

   // Stimulus and verdict.
   initial begin
      int phase_start;
      issued          = 0;
      idle_pct        = 8;
      reset           = 1'b1;
      start           = 1'b0;
      req_cmd         = CMD_NOP;
      req_page_number = '0;
      req_access      = '0;
      req_frame_in    = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: empty table, extremes, rights ordering, updates, flush.
      issue(CMD_LOOKUP, '0, 2'd0, '0);
      issue(CMD_NOP, '0, 2'd0, '0);
      issue(CMD_INSERT, '0, 2'd0, '0);
      issue(CMD_INSERT, '1, 2'd3, '1);
      issue(CMD_LOOKUP, '1, 2'd3, '0);
      issue(CMD_LOOKUP, '1, 2'd0, '1);
      issue(CMD_LOOKUP, '0, 2'd1, '0);
      issue(CMD_LOOKUP, '0, 2'd0, '0);
      issue(CMD_INSERT, '0, 2'd2, 7'h55);
      issue(CMD_LOOKUP, '0, 2'd1, '0);
      issue(CMD_INSERT, '0, 2'd2, 7'h2a);
      issue(CMD_LOOKUP, '0, 2'd2, '0);
      issue(CMD_INSERT, '1, 2'd3, 7'h01);
      issue(CMD_LOOKUP, '1, 2'd1, '0);
      issue(CMD_INSERT, '0, 2'd0, '1);
      issue(CMD_LOOKUP, '0, 2'd0, '0);
      issue(CMD_NOP, 8'haa, 2'd1, 7'h55);
      issue(CMD_FLUSH, '0, 2'd0, '0);
      issue(CMD_LOOKUP, '1, 2'd0, '0);
      issue(CMD_INSERT, 8'h55, 2'd1, 7'h2a);
      issue(CMD_LOOKUP, 8'h55, 2'd1, '0);
      issue(CMD_FLUSH, '1, 2'd3, '1);

      // Random part in three phases of sender idling; the full-table case
      // runs once before them.
      fill_to_capacity();
      for (int phase = 0; phase < 3; phase++) begin
         idle_pct    = (phase == 0) ? 8 : (phase == 1) ? 69 : 0;
         phase_start = issued;
         while (issued - phase_start < PHASE_ITEMS) run_episode();
      end
      @(negedge clock);
      start <= 1'b0;

      // Drain the outstanding responses, then allow for one full scan.
      while (pending_count != 0) @(posedge clock);
      repeat (TLB_ENTRIES + 8) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("** tlb_lookup_insert: PASSED **");
      end else begin
         $display("** tlb_lookup_insert: FAILED **");
      end
      $finish;
   end

endmodule
